// ===== rtl/core/tlblru_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the fully associative LRU translation buffer.
// Used by the controller, the datapath and the top level; depends on nothing.

package tlblru_pkg;

   localparam int VADDR_BITS  = 24;
   localparam int OFFSET_BITS = 12;
   localparam int VPN_BITS    = 12;
   localparam int PPN_BITS    = 9;
   localparam int PADDR_BITS  = PPN_BITS + OFFSET_BITS;

   localparam logic FUNC_LOOKUP = 1'b0;
   localparam logic FUNC_FILL   = 1'b1;

   typedef struct packed {
      logic                  func;
      logic [VADDR_BITS-1:0] vaddr;
      logic                  write;
      logic [PPN_BITS-1:0]   fill_ppn;
   } req_type;

   typedef struct packed {
      logic                  hit;
      logic [PADDR_BITS-1:0] paddr;
      logic                  mark_pte_dirty;
   } rsp_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic capture;
      logic execute;
      logic respond;
   } ctrl_cmd_type;

endpackage

// ===== rtl/core/tlblru_ram.sv =====
`timescale 1ns / 1ps
// Generic simple dual-port RAM: one write port, one read port with registered data.
// Standalone; no package dependencies.

module tlblru_ram #(
   parameter int WIDTH = 9,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/core/tlblru_ctrl.sv =====
`timescale 1ns / 1ps
// Sequencer for the translation buffer: accept, compare/update, respond.
// Depends on tlblru_pkg for the command struct.

module tlblru_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   output logic                    busy,
   output logic                    rsp_valid,
   output tlblru_pkg::ctrl_cmd_type cmd
);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_LOOK = 2'd1;
   localparam logic [1:0] ST_RESP = 2'd2;

   logic [1:0] state_ff;
   logic [1:0] state_in;
   logic       accept;

   assign busy   = (state_ff == ST_LOOK);
   assign accept = start && !busy;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) state_in = ST_LOOK;
         end
         ST_LOOK: begin
            state_in = ST_RESP;
         end
         ST_RESP: begin
            // take the next request while this result is on the port
            state_in = accept ? ST_LOOK : ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign cmd.capture = accept;
   assign cmd.execute = (state_ff == ST_LOOK);
   assign cmd.respond = (state_ff == ST_RESP);
   assign rsp_valid   = cmd.respond;

`ifndef NO_ASSERTIONS
   a_look_then_resp: assert property (@(posedge clock) disable iff (reset)
      cmd.execute |=> cmd.respond)
      else $error("compare cycle not followed by response");
   a_resp_after_accept: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(accept, 2))
      else $error("response without accepted request");
`endif

endmodule

// ===== rtl/core/tlblru_dp.sv =====
`timescale 1ns / 1ps
// Datapath: tag compare over all entries, victim choice, LRU rank update,
// valid/dirty/tag registers and the frame RAM. Depends on tlblru_pkg, tlblru_ram.

module tlblru_dp #(
   parameter int ENTRIES = 16
) (
   input  logic                     clock,
   input  logic                     reset,
   input  tlblru_pkg::ctrl_cmd_type cmd,
   input  tlblru_pkg::req_type      req_data,
   output tlblru_pkg::rsp_type      rsp_data
);

   localparam int IDX_W = $clog2(ENTRIES);

   tlblru_pkg::req_type              req_ff;
   logic [ENTRIES-1:0]               valid_ff;
   logic [ENTRIES-1:0]               dirty_ff;
   logic [tlblru_pkg::VPN_BITS-1:0]  vpn_ff  [ENTRIES];
   logic [IDX_W-1:0]                 rank_ff [ENTRIES];
   logic                             hit_ff;
   logic                             mark_ff;

   logic [tlblru_pkg::VPN_BITS-1:0]  req_vpn;
   logic [ENTRIES-1:0]               match;
   logic [ENTRIES-1:0]               rank_zero;
   logic [ENTRIES-1:0]               rank_last;
   logic                             any_match;
   logic [IDX_W-1:0]                 hit_idx;
   logic [IDX_W-1:0]                 free_idx;
   logic [IDX_W-1:0]                 lru_idx;
   logic [IDX_W-1:0]                 sel_idx;
   logic [IDX_W-1:0]                 old_rank;
   logic                             is_lookup;
   logic                             do_update;
   logic                             hit_in;
   logic                             mark_in;
   logic                             fill_we;
   logic [tlblru_pkg::PPN_BITS-1:0]  ram_rdata;

   assign req_vpn   = req_ff.vaddr[tlblru_pkg::OFFSET_BITS +: tlblru_pkg::VPN_BITS];
   assign is_lookup = (req_ff.func == tlblru_pkg::FUNC_LOOKUP);

   always_comb begin
      for (int i = 0; i < ENTRIES; i++) begin
         match[i]     = valid_ff[i] && (vpn_ff[i] == req_vpn);
         rank_zero[i] = (rank_ff[i] == '0);
         rank_last[i] = (rank_ff[i] == IDX_W'(ENTRIES - 1));
      end
   end

   assign any_match = |match;

   // lowest numbered match, lowest numbered free slot, and the LRU slot
   always_comb begin
      hit_idx  = '0;
      free_idx = '0;
      lru_idx  = '0;
      for (int i = ENTRIES - 1; i >= 0; i--) begin
         if (match[i])     hit_idx  = IDX_W'(i);
         if (!valid_ff[i]) free_idx = IDX_W'(i);
         if (rank_last[i]) lru_idx  = IDX_W'(i);
      end
   end

   assign sel_idx   = is_lookup ? hit_idx : ((&valid_ff) ? lru_idx : free_idx);
   assign old_rank  = rank_ff[sel_idx];
   assign do_update = cmd.execute && (!is_lookup || any_match);
   assign fill_we   = cmd.execute && !is_lookup;
   assign hit_in    = is_lookup && any_match;
   assign mark_in   = hit_in && req_ff.write && !dirty_ff[sel_idx];

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         req_ff <= req_data;
      end
      if (cmd.execute) begin
         hit_ff  <= hit_in;
         mark_ff <= mark_in;
      end
      if (fill_we) begin
         vpn_ff[sel_idx] <= req_vpn;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         dirty_ff <= '0;
         for (int i = 0; i < ENTRIES; i++) begin
            rank_ff[i] <= IDX_W'(i);
         end
      end else begin
         if (fill_we) begin
            valid_ff[sel_idx] <= 1'b1;
            dirty_ff[sel_idx] <= 1'b0;
         end else if (mark_in && cmd.execute) begin
            dirty_ff[sel_idx] <= 1'b1;
         end
         if (do_update) begin
            // move the chosen entry to the front, age the ones ahead of it
            for (int i = 0; i < ENTRIES; i++) begin
               if (IDX_W'(i) == sel_idx) begin
                  rank_ff[i] <= '0;
               end else if (rank_ff[i] < old_rank) begin
                  rank_ff[i] <= rank_ff[i] + 1'b1;
               end
            end
         end
      end
   end

   tlblru_ram #(
      .WIDTH (tlblru_pkg::PPN_BITS),
      .DEPTH (ENTRIES)
   ) u_ppn_ram (
      .clock   (clock),
      .wr_en   (fill_we),
      .wr_addr (sel_idx),
      .wr_data (req_ff.fill_ppn),
      .rd_en   (cmd.execute && is_lookup),
      .rd_addr (sel_idx),
      .rd_data (ram_rdata)
   );

   always_comb begin
      rsp_data.hit            = hit_ff;
      rsp_data.mark_pte_dirty = mark_ff;
      rsp_data.paddr          = hit_ff ?
         {ram_rdata, req_ff.vaddr[tlblru_pkg::OFFSET_BITS-1:0]} : '0;
   end

`ifndef NO_ASSERTIONS
   a_one_mru: assert property (@(posedge clock) disable iff (reset)
      $onehot(rank_zero))
      else $error("recency order lost its most recent entry");
   a_one_lru: assert property (@(posedge clock) disable iff (reset)
      $onehot(rank_last))
      else $error("recency order lost its least recent entry");
   a_fill_valid: assert property (@(posedge clock) disable iff (reset)
      fill_we |=> valid_ff[$past(sel_idx)] && rank_ff[$past(sel_idx)] == '0)
      else $error("filled entry not valid and most recent");
   a_mark_hit: assert property (@(posedge clock) disable iff (reset)
      cmd.respond && mark_ff |-> hit_ff)
      else $error("dirty mark request without a hit");
`endif

endmodule

// ===== rtl/core/tlb_lru_lookup_fill_top.sv =====
`timescale 1ns / 1ps
// Top level of the fully associative LRU translation buffer.
// Depends on tlblru_pkg, tlblru_ctrl, tlblru_dp (which holds tlblru_ram).

// Usage:
//   Request channel: drive req_data and raise start; the request is taken at a
//   rising edge where start is high and busy is low. func selects lookup or fill.
//   Response channel: rsp_valid is high for exactly one cycle with rsp_data;
//   the receiver must take it then, it cannot stall the block.
//   The compare cycle follows the accepting edge; tag compare, LRU/tag
//   update and the registered frame RAM read all finish at its closing edge.
//   The response is on the port in the next cycle. busy is high only in the
//   compare cycle, so a new request is taken while the previous response is
//   on the port.
//   The compare cycle is set by the parallel tag match, the priority select of
//   the hit or victim entry and the rank update over all ENTRIES entries.
//   A miss returns hit, paddr and mark_pte_dirty as zero; so does every fill.
//   Reset (synchronous) clears all valid and dirty marks and sets the recency
//   order to the entry index; it needs no clearing pass, the block is ready in
//   the cycle after reset drops. Tags and frame numbers are not reset.

module tlb_lru_lookup_fill_top #(
   parameter int ENTRIES = 16
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   input  tlblru_pkg::req_type req_data,
   output logic                rsp_valid,
   output tlblru_pkg::rsp_type rsp_data
);

   tlblru_pkg::ctrl_cmd_type cmd;

   tlblru_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .rsp_valid (rsp_valid),
      .cmd       (cmd)
   );

   tlblru_dp #(
      .ENTRIES (ENTRIES)
   ) u_dp (
      .clock    (clock),
      .reset    (reset),
      .cmd      (cmd),
      .req_data (req_data),
      .rsp_data (rsp_data)
   );

endmodule
